### hdl/dht_pkg.sv
// Shared types and codes of the double hash table.
package dht_pkg;

    localparam int KEY_W = 31;
    localparam int STATUS_W = 3;
    localparam int IDX_OUT_W = 6;
    localparam int SIZE_W = 7;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        TAG_EMPTY   = 2'd0,
        TAG_USED    = 2'd1,
        TAG_DELETED = 2'd2
    } tag_t;

    typedef enum logic [2:0] {
        ST_INSERTED    = 3'd0,
        ST_FULL        = 3'd1,
        ST_FOUND       = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_REMOVED     = 3'd4,
        ST_REMOVE_MISS = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_READ,
        S_PROBE,
        S_OUT
    } state_t;

endpackage

### hdl/dht_mod.sv
// Restoring bit-serial modulo unit: one quotient bit per cycle.
module dht_mod
    import dht_pkg::*;
#(
    parameter int DW = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_W-1:0]    dividend,
    input  logic [DW-1:0]       divisor,
    output logic                done,
    output logic [DW-1:0]       remainder
);

    localparam int CW = $clog2(KEY_W + 1);

    logic [DW:0]       rem_reg, rem_next;
    logic [KEY_W-1:0]  shf_reg, shf_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [DW:0]       trial;
    logic [DW:0]       rem_step;

    always_comb
    begin
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DW-1:0], shf_reg[KEY_W-1]};
        rem_step  = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
        if (start)
        begin
            rem_next  = '0;
            shf_next  = dividend;
            cnt_next  = CW'(KEY_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            shf_next = {shf_reg[KEY_W-2:0], 1'b0};
            rem_next = rem_step;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
    end

    // Final remainder of the last step; valid in the done cycle even when a
    // new run starts at the same edge.
    assign done      = busy_reg && (cnt_reg == CW'(1));
    assign remainder = rem_step[DW-1:0];

endmodule

### hdl/double_hash_table_unit.sv
// Top level of the double hash table: sequencer, slot memories and ports.
//
// Usage: an item (opcode, key) is a transfer on in_valid/in_ready. The
// block computes key mod size and 1 + key mod (size-1) on one shared
// bit-serial modulo unit, one run after the other, then walks the probe
// sequence slot by slot (memory read, then compare and step), probing at
// most size slots. An unused opcode skips all of this and answers in the
// cycle after the transfer. One item is worked at a time and in_ready is
// low meanwhile. The result (status, slot_index) is held on out_valid until
// the receiver takes it; a stalled receiver simply holds the block in its
// output state.
// table_size is written over cfg_valid/cfg_ready while idle; values below 2
// act as 2 and above MAX_SLOTS as MAX_SLOTS.
// Reset: tags clear at once through per-slot valid bits (empty), size
// returns to 7, no clearing pass is needed. Key storage is not reset.
module double_hash_table_unit
    import dht_pkg::*;
#(
    parameter int MAX_SLOTS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [KEY_W-1:0]     key,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [IDX_OUT_W-1:0] slot_index,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SIZE_W-1:0]    table_size
);

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam int DW = (NW > SIZE_W) ? NW : SIZE_W;

    state_t state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic [DW-1:0]     n_act;
    logic [1:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [IW-1:0]     pos_reg, pos_next;
    logic [IW-1:0]     step_reg;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic              phase_reg;
    logic [STATUS_W-1:0]  st_reg, st_next;
    logic [IDX_OUT_W-1:0] idx_reg, idx_next;
    logic              finish;

    logic [MAX_SLOTS-1:0] tvalid_reg;
    logic [1:0]           tag_mem [MAX_SLOTS];
    logic [KEY_W-1:0]     key_mem [MAX_SLOTS];
    logic [1:0]           tag_rd;
    logic [KEY_W-1:0]     key_rd;
    logic                 tv_rd;
    logic                 wr_en;
    logic [1:0]           wr_tag;
    logic                 wr_key;

    logic              mod_start, mod_done;
    logic [DW-1:0]     mod_div, mod_rem;
    logic [KEY_W-1:0]  mod_key;

    // Clamp the configured size to the legal range.
    always_comb
    begin
        if (size_reg < SIZE_W'(2))
            n_act = DW'(2);
        else if (DW'(size_reg) > DW'(MAX_SLOTS))
            n_act = DW'(MAX_SLOTS);
        else
            n_act = DW'(size_reg);
    end

    // The first run starts at the input transfer, before key_reg is loaded.
    assign mod_key = (state_reg == S_IDLE) ? key : key_reg;

    dht_mod #(.DW(DW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (mod_key),
        .divisor   (mod_div),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // phase_reg low: home slot run; high: step run.
    assign mod_div   = phase_reg ? (n_act - DW'(1)) : n_act;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = st_reg;
    assign slot_index = idx_reg;

    wire tag_eff_used  = tv_rd && (tag_rd == TAG_USED);
    wire tag_eff_empty = !tv_rd || (tag_rd == TAG_EMPTY);
    wire [IW:0] pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};
    wire [IW:0] pos_wrap = (pos_sum >= (IW+1)'(n_act)) ? pos_sum - (IW+1)'(n_act) : pos_sum;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid)
                     begin
                         if (op_t'(opcode) == OP_NONE)
                             state_next = S_OUT;
                         else
                             state_next = S_MOD;
                     end
            S_MOD:   if (mod_done && phase_reg) state_next = S_READ;
            S_READ:  state_next = S_PROBE;
            S_PROBE: state_next = finish ? S_OUT : S_READ;
            S_OUT:   if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory write control.
    always_comb
    begin
        pos_next = pos_wrap[IW-1:0];
        cnt_next = cnt_reg + 1'b1;
        st_next  = st_reg;
        idx_next = idx_reg;
        finish   = 1'b0;
        wr_en    = 1'b0;
        wr_tag   = TAG_USED;
        wr_key   = 1'b0;
        mod_start = 1'b0;
        if (state_reg == S_IDLE && in_valid)
        begin
            st_next  = ST_NOT_FOUND;
            idx_next = '0;
            mod_start = (op_t'(opcode) != OP_NONE);
        end
        if (state_reg == S_MOD && mod_done && !phase_reg)
            mod_start = 1'b1;
        if (state_reg == S_PROBE)
        begin
            if (op_t'(op_reg) == OP_INSERT)
            begin
                if (!tag_eff_used)
                begin
                    finish = 1'b1;
                    wr_en  = 1'b1;
                    wr_key = 1'b1;
                    st_next  = ST_INSERTED;
                    idx_next = IDX_OUT_W'(pos_reg);
                end
                else if (cnt_next == NW'(n_act))
                begin
                    finish  = 1'b1;
                    st_next = ST_FULL;
                end
            end
            else
            begin
                if (tag_eff_used && key_rd == key_reg)
                begin
                    finish = 1'b1;
                    idx_next = IDX_OUT_W'(pos_reg);
                    if (op_t'(op_reg) == OP_REMOVE)
                    begin
                        wr_en   = 1'b1;
                        wr_tag  = TAG_DELETED;
                        st_next = ST_REMOVED;
                    end
                    else
                        st_next = ST_FOUND;
                end
                else if (tag_eff_empty || cnt_next == NW'(n_act))
                begin
                    finish  = 1'b1;
                    st_next = (op_t'(op_reg) == OP_REMOVE) ? ST_REMOVE_MISS : ST_NOT_FOUND;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            size_reg   <= SIZE_W'(7);
            phase_reg  <= 1'b0;
            tvalid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                size_reg <= table_size;
            if (state_reg == S_IDLE)
                phase_reg <= 1'b0;
            else if (state_reg == S_MOD && mod_done)
                phase_reg <= 1'b1;
            if (wr_en)
                tvalid_reg[pos_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        idx_reg <= idx_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
        if (state_reg == S_MOD && mod_done)
        begin
            if (!phase_reg)
                pos_reg <= mod_rem[IW-1:0];
            else
                step_reg <= IW'(mod_rem + DW'(1));
            cnt_reg <= '0;
        end
        if (state_reg == S_PROBE)
        begin
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
        end
        if (state_reg == S_READ)
        begin
            tag_rd <= tag_mem[pos_reg];
            key_rd <= key_mem[pos_reg];
            tv_rd  <= tvalid_reg[pos_reg];
        end
        if (wr_en)
        begin
            tag_mem[pos_reg] <= wr_tag;
            if (wr_key)
                key_mem[pos_reg] <= key_reg;
        end
    end

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> DW'(pos_reg) < n_act)
        else $error("probe position out of range");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready && !cfg_ready)
        else $error("accepting while busy");

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> NW'(cnt_reg) < NW'(n_act))
        else $error("probe count overrun");

endmodule
